// ===== rtl/brzc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brzc_pkg
// shared types and constants of the mark bitmap dead-word counter
// ----------------------------------------------------------------------------
package brzc_pkg;

  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = 1024;
  localparam int TOTAL_BITS   = WORD_BITS * BITMAP_WORDS;

  localparam int ADDR_W  = 30;
  localparam int OP_W    = 2;
  localparam int WIDX_W  = 10;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int PADDR_W = 3;

  localparam int WADDR_W = $clog2(BITMAP_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int POS_W   = WADDR_W + BIT_W;
  localparam int POP_W   = $clog2(WORD_BITS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_COUNT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic REG_HEAP_START = 1'b0;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } cnt_ctrl_t;

endpackage

// ===== rtl/brzc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brzc_mem
// mark bitmap storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module brzc_mem
  import brzc_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [WADDR_W-1:0] wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic               rd_en,
  input  logic [WADDR_W-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/brzc_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brzc_count
// masks each bitmap word read back and accumulates its clear bits
// ----------------------------------------------------------------------------
module brzc_count
  import brzc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cnt_ctrl_t            ctrl,
  input  logic [WORD_BITS-1:0] rd_data,
  output logic                 fin,
  output logic [COUNT_W-1:0]   total
);

  cnt_ctrl_t            ctrl_q;
  logic [WORD_BITS-1:0] mask;
  logic [POP_W-1:0]     pop;
  logic [COUNT_W:0]     base;
  logic [COUNT_W:0]     sum;

  // control travels with the read so it lines up with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl;
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (BIT_W'(b) >= ctrl_q.lo) && (BIT_W'(b) <= ctrl_q.hi);
    end
  end

  assign pop  = POP_W'($countones(~rd_data & mask));
  assign base = ctrl_q.first ? '0 : {1'b0, total};
  assign sum  = base + (COUNT_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= ctrl_q.valid && ctrl_q.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_q.valid) begin
      total <= sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/bitmap_range_zero_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_zero_count
// mark bitmap with word writes, full clear and dead-word range count
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Each
// request gives exactly one result: done is high for one cycle with
// dead_count and range_error; the receiver cannot stall it.
// Steps per opcode:
//   write word : result in the cycle after the request, busy stays low
//   unused code: result in the cycle after the request
//   clear      : memory sweep over every word, result in the cycle after it
//   count      : a check state; a rejected or empty range answers in the
//                cycle after it, otherwise one bitmap word is read per cycle
//                from the first to the last word touched, then the read word
//                and the running total are registered before the result
// The rate is set by the single read port of the bitmap memory.
// heap_start is written through the APB port at byte address 0, by the user
// only while idle; the block does not enforce this. After reset busy stays
// high while the memory is swept to zero; configuration writes are taken in it.
// ----------------------------------------------------------------------------
module bitmap_range_zero_count
  import brzc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    opcode,
  input  logic [WIDX_W-1:0]  word_index,
  input  logic [DATA_W-1:0]  word_data,
  input  logic [ADDR_W-1:0]  first_address,
  input  logic [ADDR_W-1:0]  last_address,
  output logic               done,
  output logic [COUNT_W-1:0] dead_count,
  output logic               range_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_COUNT = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    heap_start;
  logic [ADDR_W-1:0]    first_q, last_q;
  logic [WADDR_W-1:0]   wptr, w0, w1;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic                 clr_reply;
  logic                 done_r, err_r;
  logic                 accept;
  logic                 cfg_wr;

  logic                 mem_wr_en;
  logic [WADDR_W-1:0]   mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic [WORD_BITS-1:0] rd_data;
  cnt_ctrl_t            ctrl;
  logic                 fin;
  logic [COUNT_W-1:0]   total;

  logic [ADDR_W-1:0]    fi_full, li_full, lim1_full;
  logic                 chk_err, chk_empty;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEAP_START) ? {2'b00, heap_start} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= '0;
    end else if (cfg_wr && paddr[2] == REG_HEAP_START) begin
      heap_start <= pwdata[ADDR_W-1:0];
    end
  end

  // range check on the latched request
  assign fi_full   = first_q - heap_start;
  assign li_full   = last_q - heap_start;
  assign lim1_full = li_full - ADDR_W'(1);
  assign chk_err   = (first_q < heap_start) || (last_q < heap_start) ||
                     (first_q > last_q) || (li_full > ADDR_W'(TOTAL_BITS));
  assign chk_empty = (first_q == last_q);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (wptr == WADDR_W'(BITMAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_CLEAR: state_next = S_CLEAR;
            OP_COUNT: state_next = S_CHECK;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        state_next = (chk_err || chk_empty) ? S_IDLE : S_COUNT;
      end
      S_COUNT: begin
        if (wptr == w1) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (fin) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      wptr      <= '0;
      clr_reply <= 1'b0;
      done_r    <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= 1'b0;
      err_r  <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          wptr <= wptr + WADDR_W'(1);
          if (wptr == WADDR_W'(BITMAP_WORDS - 1)) begin
            done_r <= clr_reply;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (op_t'(opcode))
              OP_CLEAR: begin
                wptr      <= '0;
                clr_reply <= 1'b1;
              end
              OP_COUNT: ;
              default:  done_r <= 1'b1;
            endcase
          end
        end
        S_CHECK: begin
          if (chk_err || chk_empty) begin
            done_r <= 1'b1;
            err_r  <= chk_err;
          end
          wptr <= fi_full[POS_W-1:BIT_W];
        end
        S_COUNT: begin
          wptr <= wptr + WADDR_W'(1);
        end
        S_WAIT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_q <= first_address;
      last_q  <= last_address;
    end
    if (state == S_CHECK) begin
      w0     <= fi_full[POS_W-1:BIT_W];
      w1     <= lim1_full[POS_W-1:BIT_W];
      lo_bit <= fi_full[BIT_W-1:0];
      hi_bit <= lim1_full[BIT_W-1:0];
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = wptr;
    mem_wr_data = '0;
    if (state == S_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if (accept && op_t'(opcode) == OP_WRITE) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = WADDR_W'(word_index);
      mem_wr_data = WORD_BITS'(word_data);
    end
  end

  always_comb begin
    ctrl.valid = (state == S_COUNT);
    ctrl.first = (wptr == w0);
    ctrl.last  = (wptr == w1);
    ctrl.lo    = (wptr == w0) ? lo_bit : '0;
    ctrl.hi    = (wptr == w1) ? hi_bit : BIT_W'(WORD_BITS - 1);
  end

  brzc_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (ctrl.valid),
    .rd_addr (wptr),
    .rd_data (rd_data)
  );

  brzc_count u_count (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_data (rd_data),
    .fin     (fin),
    .total   (total)
  );

  assign done        = done_r || fin;
  assign dead_count  = fin ? total : '0;
  assign range_error = err_r;

  // count completion only while waiting for it
  a_fin_in_wait: assert property (@(posedge clk) disable iff (rst)
    fin |-> state == S_WAIT)
    else $error("count finished outside wait");

  // no bitmap write while a count is reading
  a_no_write_in_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT || state == S_WAIT) |-> !mem_wr_en)
    else $error("bitmap written during count");

  // reset starts the clearing sweep
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("idle straight after reset");

  // a rejected range never carries a count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    range_error |-> (done && dead_count == '0))
    else $error("range error with count");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mark bitmap dead-word counter. A short table of
// directed requests covers the range extremes, every opcode and each kind of
// rejected range. Random requests follow, in phases with different heap
// start values. Each result is compared with the outcome typed in its table row
// or else with a bit-level model of the bitmap that the bench keeps itself.
// ----------------------------------------------------------------------------
module tb;
  import brzc_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 580;
  localparam int PHASES       = 6;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct packed {
    logic [ADDR_W-1:0]  heap;
    op_t                op;
    logic [WIDX_W-1:0]  widx;
    logic [DATA_W-1:0]  wdata;
    logic [ADDR_W-1:0]  first_addr;
    logic [ADDR_W-1:0]  last_addr;
    logic               known;
    logic [COUNT_W-1:0] cnt;
    logic               err;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               err;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    opcode;
  logic [WIDX_W-1:0]  word_index;
  logic [DATA_W-1:0]  word_data;
  logic [ADDR_W-1:0]  first_address;
  logic [ADDR_W-1:0]  last_address;
  logic               done;
  logic [COUNT_W-1:0] dead_count;
  logic               range_error;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [WORD_BITS-1:0] mark_model [BITMAP_WORDS];
  logic [ADDR_W-1:0]    heap_base;
  outcome_t             pending_outcomes [$];
  int                   mismatches = 0;
  int                   cycle_count = 0;
  int                   last_written = 0;
  bit                   steady = 1'b0;

  bitmap_range_zero_count uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .word_index    (word_index),
    .word_data     (word_data),
    .first_address (first_address),
    .last_address  (last_address),
    .done          (done),
    .dead_count    (dead_count),
    .range_error   (range_error),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycle_count);
    end
  endtask

  // bitmap model: applies one request and returns the result it should give
  function automatic outcome_t apply_request(request_t q);
    outcome_t        r;
    longint unsigned fi;
    longint unsigned li;
    longint unsigned n;
    r = '0;
    case (q.op)
      OP_CLEAR: begin
        for (int i = 0; i < BITMAP_WORDS; i++) mark_model[i] = '0;
      end
      OP_WRITE: begin
        mark_model[q.widx] = q.wdata;
      end
      OP_COUNT: begin
        if (q.first_addr < heap_base || q.last_addr < heap_base || q.first_addr > q.last_addr) begin
          r.err = 1'b1;
        end else begin
          fi = q.first_addr - heap_base;
          li = q.last_addr - heap_base;
          if (li > TOTAL_BITS) begin
            r.err = 1'b1;
          end else begin
            n = 0;
            for (longint unsigned i = fi; i < li; i++) begin
              if (!mark_model[i / WORD_BITS][i % WORD_BITS]) n++;
            end
            r.cnt = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic request_t dir_row(logic [ADDR_W-1:0] heap, op_t op,
                                       logic [WIDX_W-1:0] widx, logic [DATA_W-1:0] wdata,
                                       logic [ADDR_W-1:0] first_addr,
                                       logic [ADDR_W-1:0] last_addr, logic known,
                                       logic [COUNT_W-1:0] cnt, logic err);
    request_t q;
    q.heap       = heap;
    q.op         = op;
    q.widx       = widx;
    q.wdata      = wdata;
    q.first_addr = first_addr;
    q.last_addr  = last_addr;
    q.known      = known;
    q.cnt        = cnt;
    q.err        = err;
    return q;
  endfunction

  // heap-relative offset to address; anything unrepresentable becomes noise
  function automatic logic [ADDR_W-1:0] heap_addr(longint rel);
    longint a;
    a = longint'(heap_base) + rel;
    if (a < 0 || a > longint'(ADDR_TOP)) return ADDR_W'($urandom);
    return ADDR_W'(a);
  endfunction

  function automatic request_t random_request();
    request_t    q;
    int unsigned pick;
    longint      rf;
    longint      rl;
    q.heap       = heap_base;
    q.known      = 1'b0;
    q.cnt        = '0;
    q.err        = 1'b0;
    q.widx       = WIDX_W'($urandom);
    q.wdata      = $urandom;
    q.first_addr = ADDR_W'($urandom);
    q.last_addr  = ADDR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      q.op = OP_CLEAR;
    end else if (pick < 7) begin
      q.op = OP_NONE;
    end else if (pick < 50) begin
      q.op = OP_WRITE;
      case ($urandom_range(0, 4))
        0: q.wdata = '1;
        1: q.wdata = '0;
        2: q.wdata = $urandom & $urandom & $urandom;
        default: ;
      endcase
      last_written = q.widx;
    end else begin
      q.op = OP_COUNT;
      pick = $urandom_range(0, 99);
      if (pick < 93) begin
        if (pick < 6) begin
          // near full heap span
          rf = longint'($urandom_range(0, 64));
          rl = TOTAL_BITS - longint'($urandom_range(0, 64));
        end else if (pick < 70) begin
          if ($urandom_range(0, 1) == 1) begin
            rf = longint'(last_written) * WORD_BITS + longint'($urandom_range(0, 80)) - 40;
          end else begin
            rf = longint'($urandom_range(0, TOTAL_BITS));
          end
          if (rf < 0) rf = 0;
          rl = rf + longint'($urandom_range(0, 200));
          if (rl > TOTAL_BITS) rl = TOTAL_BITS;
        end else if (pick < 78) begin
          // past the end of the heap
          rf = longint'($urandom_range(0, TOTAL_BITS));
          rl = TOTAL_BITS + longint'($urandom_range(1, 100));
        end else if (pick < 86) begin
          // reversed
          rl = longint'($urandom_range(0, TOTAL_BITS - 1));
          rf = rl + longint'($urandom_range(1, 50));
        end else if ($urandom_range(0, 1) == 1) begin
          // start below the heap
          rf = -longint'($urandom_range(1, 1000));
          rl = longint'($urandom_range(0, 500));
        end else begin
          // end below the heap
          rf = longint'($urandom_range(0, 500));
          rl = -longint'($urandom_range(1, 1000));
        end
        q.first_addr = heap_addr(rf);
        q.last_addr  = heap_addr(rl);
      end
    end
    return q;
  endfunction

  task automatic issue(request_t q);
    outcome_t predicted;
    outcome_t typed;
    opcode        <= q.op;
    word_index    <= q.widx;
    word_data     <= q.wdata;
    first_address <= q.first_addr;
    last_address  <= q.last_addr;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(q);
    typed.cnt = q.cnt;
    typed.err = q.err;
    if (q.known) pending_outcomes.push_back(typed);
    else pending_outcomes.push_back(predicted);
  endtask

  task automatic run_item(request_t q);
    int gap;
    issue(q);
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_heap_start(logic [ADDR_W-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_HEAP_START, 2'b00});
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[ADDR_W-1:0] !== v) flag_mismatch("heap_start readback", v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    heap_base = v;
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** bitmap_range_zero_count: FAILED **");
      $finish;
    end else if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result, dead_count", 0, dead_count);
      end else begin
        want = pending_outcomes.pop_front();
        if (dead_count !== want.cnt) flag_mismatch("dead_count", want.cnt, dead_count);
        if (range_error !== want.err) flag_mismatch("range_error", want.err, range_error);
      end
    end
  end

  initial begin : stimulus
    request_t          rows [$];
    logic [ADDR_W-1:0] phase_heaps [PHASES];
    rst           = 1'b1;
    start         = 1'b0;
    opcode        = OP_NONE;
    word_index    = '0;
    word_data     = '0;
    first_address = '0;
    last_address  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    heap_base     = '0;
    for (int i = 0; i < BITMAP_WORDS; i++) mark_model[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_heap_start('0);

    // heap, op, index, data, first, last, typed, count, error
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 0, TOTAL_BITS, 1, TOTAL_BITS, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 5, 4, 1, 0, 1));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 0, TOTAL_BITS + 1, 1, 0, 1));
    rows.push_back(dir_row(0, OP_WRITE, 0, '1, 0, 0, 1, 0, 0));
    rows.push_back(dir_row(0, OP_WRITE, BITMAP_WORDS - 1, 32'h8000_0001, 0, 0, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 0, WORD_BITS, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, TOTAL_BITS - WORD_BITS, TOTAL_BITS, 0, 0, 0));
    rows.push_back(dir_row(0, OP_NONE, '1, '1, ADDR_TOP, ADDR_TOP, 1, 0, 0));
    rows.push_back(dir_row(0, OP_WRITE, 5, 32'hA5A5_A5A5, 0, 0, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 160, 192, 0, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 3, 170, 0, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, ADDR_TOP, ADDR_TOP, 1, 0, 1));
    rows.push_back(dir_row(0, OP_CLEAR, '1, '1, '1, '1, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 0, TOTAL_BITS, 1, TOTAL_BITS, 0));
    rows.push_back(dir_row(0, OP_WRITE, 512, 32'h0000_FFFF, 0, 0, 1, 0, 0));
    rows.push_back(dir_row(0, OP_COUNT, 0, 0, 16380, 16420, 0, 0, 0));
    rows.push_back(dir_row(100, OP_COUNT, 0, 0, 99, 200, 1, 0, 1));
    rows.push_back(dir_row(100, OP_COUNT, 0, 0, 100, 99, 1, 0, 1));
    rows.push_back(dir_row(100, OP_COUNT, 0, 0, 100, 100 + TOTAL_BITS, 0, 0, 0));
    rows.push_back(dir_row(100, OP_COUNT, 0, 0, 100 + TOTAL_BITS, 100 + TOTAL_BITS, 1, 0, 0));
    rows.push_back(dir_row(100, OP_COUNT, 0, 0, 100, 101 + TOTAL_BITS, 1, 0, 1));
    rows.push_back(dir_row(ADDR_TOP, OP_COUNT, 0, 0, ADDR_TOP, ADDR_TOP, 1, 0, 0));
    rows.push_back(dir_row(ADDR_TOP, OP_COUNT, 0, 0, 0, ADDR_TOP, 1, 0, 1));

    foreach (rows[i]) begin
      if (rows[i].heap != heap_base) set_heap_start(rows[i].heap);
      run_item(rows[i]);
    end

    phase_heaps[0] = '0;
    phase_heaps[1] = ADDR_W'($urandom);
    phase_heaps[2] = ADDR_TOP - ADDR_W'(TOTAL_BITS - 1);
    phase_heaps[3] = ADDR_TOP;
    phase_heaps[4] = ADDR_W'($urandom_range(1, 1 << 20));
    phase_heaps[5] = ADDR_W'($urandom_range(1, 64));

    for (int p = 0; p < PHASES; p++) begin
      set_heap_start(phase_heaps[p]);
      for (int i = 0; i < RANDOM_ITEMS / PHASES + 1; i++) begin
        if (i % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 3) drain();
        run_item(random_request());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** bitmap_range_zero_count: PASSED **");
    end else begin
      $display("** bitmap_range_zero_count: FAILED **");
    end
    $finish;
  end

endmodule
